// ===== hdl/mlfs_pkg.sv =====
// mlfs_pkg: types, constants and codes for the multilevel feedback scheduler
// no dependencies; used by every module of the block except mlfs_ram

package mlfs_pkg;

	localparam int MAX_PROCS_DEF = 16;
	localparam int AGE_BITS_DEF  = 8;
	localparam int NCLASS        = 3;
	localparam int NLEVEL        = 3;
	localparam int NQUEUE        = 9;
	localparam int QW            = 4;   // queue number width
	localparam int PID_W         = 4;
	localparam int CFG_W         = 8;
	localparam int CFG_IDX_W     = 3;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_QUANTUM0 = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_QUANTUM1 = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_QUANTUM2 = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LIMIT1   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_LIMIT2   = 3'd4;

	// request codes
	localparam logic [1:0] REQ_ADMIT    = 2'd0;
	localparam logic [1:0] REQ_SCHEDULE = 2'd1;
	localparam logic [1:0] REQ_RETURN   = 2'd2;
	localparam logic [1:0] REQ_RESERVED = 2'd3;   // ignored, all-zero result

	typedef struct packed {
		logic [1:0] req_type;
		logic [3:0] pid;
		logic [1:0] proc_class;
		logic [1:0] run_level;
	} req_t;

	typedef struct packed {
		logic       found;
		logic [3:0] out_pid;
		logic [1:0] out_class;
		logic [1:0] out_level;
		logic [7:0] slice;
		logic       overflow;
	} rsp_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_AGE_SEL,   // pick next aged queue, latch its count
		ST_AGE_RD,    // issue read of head entry
		ST_AGE_WAIT,  // read data arrives, head read held
		ST_AGE_WR,    // decide and write back
		ST_SCAN,      // find first nonempty queue
		ST_DQ_WAIT,   // read data for head
		ST_DONE
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic       push_req;    // admit/return enqueue
		logic       age_load;    // latch fill of current aged queue
		logic       rd_head;     // read head of selected queue
		logic       age_write;   // pop aged entry and push it somewhere
		logic       scan;        // pop head of first nonempty queue
		logic       finish;      // emit result
		logic [3:0] q_sel;       // queue under aging
	} ctl_t;

	// datapath to controller
	typedef struct packed {
		logic age_more;   // entries left in current aged queue
	} sts_t;

	function automatic logic [1:0] class_of(input logic [1:0] c);
		return (c == 2'd3) ? 2'd2 : c;
	endfunction

endpackage

// ===== hdl/mlfs_ram.sv =====
// mlfs_ram: generic single-write, single-read RAM with registered read
// no dependencies

module mlfs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== hdl/mlfs_ctrl.sv =====
// mlfs_ctrl: sequencer for admit, aging pass and dequeue
// depends on mlfs_pkg

module mlfs_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [1:0]        req_type,
	input  mlfs_pkg::sts_t    sts,
	output mlfs_pkg::ctl_t    ctl,
	output logic              busy
);

	mlfs_pkg::state_t state_q, state_d;
	logic [3:0] q_q, q_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mlfs_pkg::ST_IDLE;
			q_q     <= 4'd1;
		end else begin
			state_q <= state_d;
			q_q     <= q_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d = state_q;
		q_d     = q_q;
		ctl     = '0;
		ctl.q_sel = q_q;
		busy    = (state_q != mlfs_pkg::ST_IDLE);
		case (state_q)
			mlfs_pkg::ST_IDLE: begin
				if (start) begin
					if (req_type == mlfs_pkg::REQ_SCHEDULE) begin
						q_d     = 4'd1;
						state_d = mlfs_pkg::ST_AGE_SEL;
					end else begin
						ctl.push_req = 1'b1;
						state_d      = mlfs_pkg::ST_DONE;
					end
				end
			end
			mlfs_pkg::ST_AGE_SEL: begin
				ctl.age_load = 1'b1;
				state_d      = mlfs_pkg::ST_AGE_RD;
			end
			mlfs_pkg::ST_AGE_RD: begin
				if (sts.age_more) begin
					ctl.rd_head = 1'b1;
					state_d     = mlfs_pkg::ST_AGE_WAIT;
				end else if (q_q == 4'd8) begin
					ctl.rd_head = 1'b1;
					state_d     = mlfs_pkg::ST_SCAN;
				end else begin
					// levels 1,2 of each class: 1,2,4,5,7,8
					q_d     = (q_q == 4'd2 || q_q == 4'd5) ? q_q + 4'd2 : q_q + 4'd1;
					state_d = mlfs_pkg::ST_AGE_SEL;
				end
			end
			mlfs_pkg::ST_AGE_WAIT: begin
				// keep the head address so the read data holds for the write-back
				ctl.rd_head = 1'b1;
				state_d     = mlfs_pkg::ST_AGE_WR;
			end
			mlfs_pkg::ST_AGE_WR: begin
				ctl.age_write = 1'b1;
				state_d       = mlfs_pkg::ST_AGE_RD;
			end
			mlfs_pkg::ST_SCAN: begin
				// head read of the chosen queue issued this cycle
				ctl.rd_head = 1'b1;
				state_d     = mlfs_pkg::ST_DQ_WAIT;
			end
			mlfs_pkg::ST_DQ_WAIT: begin
				ctl.scan = 1'b1;
				state_d  = mlfs_pkg::ST_DONE;
			end
			mlfs_pkg::ST_DONE: begin
				ctl.finish = 1'b1;
				state_d    = mlfs_pkg::ST_IDLE;
			end
			default: begin
				state_d = mlfs_pkg::ST_IDLE;
			end
		endcase
	end

	// aged queue is always a level 1 or 2 queue
	a_qsel: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == mlfs_pkg::ST_AGE_WR |-> q_q != 4'd0 && q_q != 4'd3 && q_q != 4'd6)
		else $error("aging a level 0 queue");
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted item without going busy");
	a_done: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == mlfs_pkg::ST_DONE |=> state_q == mlfs_pkg::ST_IDLE)
		else $error("done not followed by idle");

endmodule

// ===== hdl/mlfs_dp.sv =====
// mlfs_dp: queue pointers, entry RAM, config registers and result register
// depends on mlfs_pkg and mlfs_ram

module mlfs_dp #(
	parameter int MAX_PROCS = mlfs_pkg::MAX_PROCS_DEF,
	parameter int AGE_BITS  = mlfs_pkg::AGE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  mlfs_pkg::req_t                req,
	input  logic                          cfg_we,
	input  logic [mlfs_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [mlfs_pkg::CFG_W-1:0]     cfg_data,
	input  mlfs_pkg::ctl_t                ctl,
	output mlfs_pkg::sts_t                sts,
	output mlfs_pkg::rsp_t                rsp,
	output logic                          done
);

	localparam int SW = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
	localparam int FW = $clog2(MAX_PROCS + 1);
	localparam int DEPTH = mlfs_pkg::NQUEUE * MAX_PROCS;
	localparam int AW = $clog2(DEPTH);
	localparam int EW = AGE_BITS + mlfs_pkg::PID_W;
	localparam logic [AGE_BITS-1:0] AGE_MAX = '1;
	localparam logic [FW-1:0] FULL = FW'(MAX_PROCS);

	logic [SW-1:0] head_q [mlfs_pkg::NQUEUE];
	logic [FW-1:0] fill_q [mlfs_pkg::NQUEUE];
	logic [7:0]    quant_q [mlfs_pkg::NLEVEL];
	logic [7:0]    lim1_q, lim2_q;
	logic [1:0]    cls_q;
	logic [1:0]    lvl_q;
	logic [3:0]    pid_q;
	logic [FW-1:0] cnt_q;
	logic          ovf_q, found_q;
	logic [3:0]    dq_q;

	logic          we;
	logic [AW-1:0] waddr, raddr;
	logic [EW-1:0] wdata, rdata;
	logic [3:0]    rq;

	// slot address of queue q, offset (head + off) mod MAX_PROCS
	function automatic logic [AW-1:0] slot_addr(input logic [3:0] q,
			input logic [SW-1:0] h, input logic [FW-1:0] off);
		logic [SW:0] s;
		logic [SW:0] m;
		m = (SW+1)'(MAX_PROCS);
		s = {1'b0, h} + (SW+1)'(off);
		if (s >= m) s = s - m;
		return AW'(q) * AW'(MAX_PROCS) + AW'(s);
	endfunction

	// first nonempty queue, class then level order
	logic [3:0] first_q;
	logic       any_q;
	always_comb begin
		first_q = 4'd0;
		any_q   = 1'b0;
		for (int i = mlfs_pkg::NQUEUE - 1; i >= 0; i--) begin
			if (fill_q[i] != '0) begin
				first_q = 4'(i);
				any_q   = 1'b1;
			end
		end
	end

	// request decode for admit/return
	logic [1:0] rcls;
	logic [3:0] push_q;
	always_comb begin
		rcls   = mlfs_pkg::class_of(req.proc_class);
		push_q = 4'(rcls) * 4'd3;
		if (req.req_type == mlfs_pkg::REQ_RETURN)
			push_q = push_q + ((req.run_level != 2'd0) ? 4'd2 : 4'd1);
	end
	logic push_ok;
	assign push_ok = (req.req_type == mlfs_pkg::REQ_ADMIT ||
		req.req_type == mlfs_pkg::REQ_RETURN);

	// aging decision on the entry just read
	logic [AGE_BITS-1:0] age_inc, age_lim, age_keep;
	logic [7:0] lim_sel;
	logic [3:0] to_q;
	logic       promote, to_full;
	always_comb begin
		age_inc = rdata[EW-1:4];
		if (age_inc != AGE_MAX) age_inc = age_inc + 1'b1;
		if (ctl.q_sel == 4'd1 || ctl.q_sel == 4'd4 || ctl.q_sel == 4'd7)
			age_lim = (AGE_BITS >= 8) ? AGE_BITS'(lim1_q)
				: ((lim1_q > 8'(AGE_MAX)) ? AGE_MAX : AGE_BITS'(lim1_q));
		else
			age_lim = (AGE_BITS >= 8) ? AGE_BITS'(lim2_q)
				: ((lim2_q > 8'(AGE_MAX)) ? AGE_MAX : AGE_BITS'(lim2_q));
		lim_sel = (ctl.q_sel == 4'd1 || ctl.q_sel == 4'd4 || ctl.q_sel == 4'd7)
			? lim1_q : lim2_q;
		promote = (16'(age_inc) >= 16'(lim_sel));
		to_q    = ctl.q_sel - 4'd1;
		to_full = (fill_q[to_q] == FULL);
		age_keep = (promote && to_full) ? age_lim : age_inc;
	end

	// ram port muxing
	assign rq = ctl.rd_head ? (ctl.q_sel == 4'd8 && cnt_q == '0 &&
		!(ctl.age_write) ? first_q : ctl.q_sel) : first_q;
	always_comb begin
		we    = 1'b0;
		waddr = '0;
		wdata = '0;
		raddr = slot_addr(rq, head_q[rq], '0);
		if (ctl.push_req && push_ok && fill_q[push_q] != FULL) begin
			we    = 1'b1;
			waddr = slot_addr(push_q, head_q[push_q], fill_q[push_q]);
			wdata = {{AGE_BITS{1'b0}}, req.pid};
		end else if (ctl.age_write) begin
			we = 1'b1;
			if (promote && !to_full) begin
				waddr = slot_addr(to_q, head_q[to_q], fill_q[to_q]);
				wdata = {{AGE_BITS{1'b0}}, rdata[3:0]};
			end else begin
				// head pops and tail pushes in one step: tail is slot head+fill
				waddr = slot_addr(ctl.q_sel, head_q[ctl.q_sel], fill_q[ctl.q_sel]);
				wdata = {age_keep, rdata[3:0]};
			end
		end
	end

	mlfs_ram #(.WIDTH(EW), .DEPTH(DEPTH)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.raddr(raddr), .rdata(rdata)
	);

	assign sts.age_more = (cnt_q != '0);

	// pointers, counters, config and result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < mlfs_pkg::NQUEUE; i++) begin
				head_q[i] <= '0;
				fill_q[i] <= '0;
			end
			quant_q[0] <= 8'd2;
			quant_q[1] <= 8'd4;
			quant_q[2] <= 8'd6;
			lim1_q  <= 8'd3;
			lim2_q  <= 8'd6;
			cnt_q   <= '0;
			ovf_q   <= 1'b0;
			found_q <= 1'b0;
			done    <= 1'b0;
			cls_q   <= '0;
			lvl_q   <= '0;
			pid_q   <= '0;
			dq_q    <= '0;
			rsp     <= '0;
		end else begin
			done <= 1'b0;
			if (cfg_we) begin
				case (cfg_idx)
					mlfs_pkg::REG_QUANTUM0: quant_q[0] <= cfg_data;
					mlfs_pkg::REG_QUANTUM1: quant_q[1] <= cfg_data;
					mlfs_pkg::REG_QUANTUM2: quant_q[2] <= cfg_data;
					mlfs_pkg::REG_LIMIT1:   lim1_q     <= cfg_data;
					mlfs_pkg::REG_LIMIT2:   lim2_q     <= cfg_data;
					default: ;
				endcase
			end
			if (ctl.push_req) begin
				found_q <= 1'b0;
				ovf_q   <= 1'b0;
				if (push_ok) begin
					if (fill_q[push_q] != FULL)
						fill_q[push_q] <= fill_q[push_q] + 1'b1;
					else
						ovf_q <= 1'b1;
				end
			end
			if (ctl.age_load) begin
				cnt_q <= fill_q[ctl.q_sel];
				if (ctl.q_sel == 4'd1) begin
					ovf_q   <= 1'b0;
					found_q <= 1'b0;
				end
			end
			if (ctl.rd_head) dq_q <= rq;
			if (ctl.age_write) begin
				cnt_q <= cnt_q - 1'b1;
				head_q[ctl.q_sel] <= (head_q[ctl.q_sel] == SW'(MAX_PROCS - 1))
					? '0 : head_q[ctl.q_sel] + 1'b1;
				if (promote && !to_full) begin
					fill_q[ctl.q_sel] <= fill_q[ctl.q_sel] - 1'b1;
					fill_q[to_q]      <= fill_q[to_q] + 1'b1;
				end else if (promote) begin
					ovf_q <= 1'b1;
				end
			end
			if (ctl.scan) begin
				found_q <= any_q;
				if (any_q) begin
					pid_q <= rdata[3:0];
					cls_q <= (dq_q >= 4'd6) ? 2'd2 : (dq_q >= 4'd3) ? 2'd1 : 2'd0;
					lvl_q <= 2'(dq_q - ((dq_q >= 4'd6) ? 4'd6 : (dq_q >= 4'd3) ? 4'd3 : 4'd0));
					head_q[dq_q] <= (head_q[dq_q] == SW'(MAX_PROCS - 1))
						? '0 : head_q[dq_q] + 1'b1;
					fill_q[dq_q] <= fill_q[dq_q] - 1'b1;
				end
			end
			if (ctl.finish) begin
				done <= 1'b1;
				rsp.overflow <= ovf_q;
				rsp.found    <= found_q;
				rsp.out_pid  <= found_q ? pid_q : '0;
				rsp.out_class <= found_q ? cls_q : '0;
				rsp.out_level <= found_q ? lvl_q : '0;
				rsp.slice    <= found_q ? quant_q[lvl_q] : '0;
			end
		end
	end

	a_fill: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q[0] <= FULL && fill_q[8] <= FULL)
		else $error("fill beyond depth");
	a_found: assert property (@(posedge clk) disable iff (!arst_n)
		done && !rsp.found |-> rsp.slice == '0)
		else $error("slice without found");
	a_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.age_write |-> cnt_q != '0)
		else $error("aging with no entry left");

endmodule

// ===== hdl/multilevel_feedback_scheduler_core.sv =====
// multilevel_feedback_scheduler_core: top level of the scheduler
// depends on mlfs_pkg, mlfs_ctrl, mlfs_dp (which uses mlfs_ram)
//
// Usage: drive req and pulse start while busy is low; the request is taken at
// that edge. A schedule request ages the level 1 and 2 queues of all classes,
// then dequeues the head of the first nonempty queue. For each of the six aged
// queues the sequencer latches its count, then reads, decides on and writes
// back each queued entry in turn; the dequeue then reads and pops the head.
// All items go through one entry RAM with one write and one registered read
// port.
// Each request yields exactly one beat on rsp, marked by valid for one cycle;
// the receiver cannot stall, so the beat must be taken when shown.
// Configuration: cfg_we, cfg_idx, cfg_data write a register at once; write only
// while busy is low (the block does not enforce this). Reset empties all queues
// and restores the register defaults; the entry RAM needs no clearing pass.

module multilevel_feedback_scheduler_core #(
	parameter int MAX_PROCS = mlfs_pkg::MAX_PROCS_DEF,
	parameter int AGE_BITS  = mlfs_pkg::AGE_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  mlfs_pkg::req_t                 req,
	output logic                           valid,
	output mlfs_pkg::rsp_t                 rsp,
	input  logic                           cfg_we,
	input  logic [mlfs_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [mlfs_pkg::CFG_W-1:0]     cfg_data
);

	mlfs_pkg::ctl_t ctl;
	mlfs_pkg::sts_t sts;

	mlfs_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .req_type(req.req_type),
		.sts(sts), .ctl(ctl), .busy(busy)
	);

	mlfs_dp #(.MAX_PROCS(MAX_PROCS), .AGE_BITS(AGE_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n), .req(req), .cfg_we(cfg_we),
		.cfg_idx(cfg_idx), .cfg_data(cfg_data), .ctl(ctl), .sts(sts),
		.rsp(rsp), .done(valid)
	);

endmodule
